### design/ctrp_pkg.sv
// ----------------------------------------------------------------------------
// ctrp_pkg
// Types, protocol constants and small helper functions shared by the
// transport-protocol receive reassembler.
// ----------------------------------------------------------------------------
package ctrp_pkg;

    typedef enum logic [1:0] {
        KIND_CTS     = 2'd0,
        KIND_EOM_ACK = 2'd1,
        KIND_SEGMENT = 2'd2,
        KIND_FORWARD = 2'd3
    } kind_t;

    localparam logic [7:0]  PGN_CONN_MGMT = 8'hEC;
    localparam logic [7:0]  PGN_DATA      = 8'hEB;
    localparam logic [7:0]  PRI_TP        = 8'h1C;
    localparam logic [7:0]  CTRL_RTS      = 8'h10;
    localparam logic [7:0]  CTRL_ABORT    = 8'hFF;
    localparam logic [7:0]  CTRL_CTS      = 8'd17;
    localparam logic [7:0]  CTRL_EOM_ACK  = 8'd19;
    localparam logic [7:0]  FILL_BYTE     = 8'hFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1100;
    localparam logic [3:0]  SEG_BYTES     = 4'd7;
    localparam logic [3:0]  FULL_FRAME    = 4'd8;

    typedef struct packed {
        logic [28:0]     frame_id;
        logic [3:0]      frame_length;
        logic [7:0][7:0] data;          // data[0] is byte0
    } frame_t;

    typedef struct packed {
        kind_t           kind;
        logic [7:0]      group_code;
        logic [3:0]      count;
        logic [7:0][7:0] data;          // data[0] is out0
        logic            last;
    } result_t;

    typedef struct packed {
        logic session_open;
    } eng_status_t;

    typedef struct packed {
        logic       check;
        logic [7:0] pri;
    } pri_rule_t;

    // Priority filter for ordinary frames, keyed by the PGN byte.
    function automatic pri_rule_t needed_priority(input logic [7:0] pgn);
        pri_rule_t r;
        r.check = 1'b1;
        unique case (pgn)
            8'h27, 8'h10, 8'h1C, 8'h13: r.pri = 8'h18;
            8'h11, 8'h15, 8'h16, 8'h17: r.pri = 8'h1C;
            8'h09, 8'h19:               r.pri = 8'h10;
            8'h1E:                      r.pri = 8'h08;
            default:
            begin
                r.check = 1'b0;
                r.pri   = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic logic allowed_group(input logic [23:0] g);
        return g == 24'h000200 || g == 24'h000600 || g == 24'h001100 ||
               g == 24'h001500 || g == 24'h001600 || g == 24'h001700;
    endfunction

    // Builds a result; bytes at or above the count read as zero.
    function automatic result_t make_result(input kind_t kind, input logic [7:0] grp,
                                            input logic [3:0] cnt,
                                            input logic [7:0][7:0] bytes,
                                            input logic last);
        result_t r;
        r.kind       = kind;
        r.group_code = grp;
        r.count      = cnt;
        r.last       = last;
        for (int i = 0; i < 8; i++)
        begin
            r.data[i] = (4'(i) < cnt) ? bytes[i] : 8'h00;
        end
        return r;
    endfunction

endpackage

### design/ctrp_engine.sv
// ----------------------------------------------------------------------------
// ctrp_engine
// Session state and the single-pass decision logic for one received frame.
// ----------------------------------------------------------------------------
module ctrp_engine
    import ctrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  frame_t      frame,
    input  logic [15:0] max_len,
    output logic [1:0]  res_n,
    output result_t     res0,
    output result_t     res1,
    output eng_status_t status
);

    logic        open_reg,   open_next;
    logic [15:0] total_reg,  total_next;
    logic [7:0]  ptotal_reg, ptotal_next;
    logic [15:0] rcv_reg,    rcv_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [23:0] group_reg,  group_next;

    logic [7:0]  pri;
    logic [7:0]  pgn;
    logic [23:0] req_group;
    logic [15:0] req_len;
    logic [15:0] rem;
    logic [7:0]  mid;
    logic [3:0]  fwd_count;
    pri_rule_t   rule;

    assign pri       = {3'b000, frame.frame_id[28:24]};
    assign pgn       = frame.frame_id[23:16];
    assign req_group = {frame.data[5], frame.data[6], frame.data[7]};
    assign req_len   = {frame.data[2], frame.data[1]};
    assign rem       = total_reg - rcv_reg;
    assign mid       = group_reg[15:8];
    assign fwd_count = (frame.frame_length > FULL_FRAME) ? FULL_FRAME : frame.frame_length;
    assign rule      = needed_priority(pgn);

    always_comb
    begin
        open_next   = open_reg;
        total_next  = total_reg;
        ptotal_next = ptotal_reg;
        rcv_next    = rcv_reg;
        seq_next    = seq_reg;
        group_next  = group_reg;
        res_n       = 2'd0;
        res0        = '0;
        res1        = '0;

        priority if (pgn == PGN_CONN_MGMT)
        begin
            if (pri == PRI_TP)
            begin
                if (frame.data[0] == CTRL_RTS)
                begin
                    if (allowed_group(req_group))
                    begin
                        total_next  = req_len;
                        ptotal_next = frame.data[3];
                        rcv_next    = 16'd0;
                        seq_next    = 8'd1;
                        group_next  = req_group;
                        open_next   = (req_len <= max_len);
                        if (req_len <= max_len)
                        begin
                            res_n = 2'd1;
                            res0  = make_result(KIND_CTS, frame.data[6], FULL_FRAME,
                                        {frame.data[7], frame.data[6], frame.data[5],
                                         FILL_BYTE, FILL_BYTE, 8'd1, frame.data[3],
                                         CTRL_CTS}, 1'b1);
                        end
                    end
                end
                else if (frame.data[0] == CTRL_ABORT)
                begin
                    open_next = 1'b0;
                end
            end
        end
        else if (pgn == PGN_DATA && open_reg)
        begin
            if (pri == PRI_TP && seq_reg == frame.data[0] && seq_reg <= ptotal_reg)
            begin
                if (rem > 16'(SEG_BYTES))
                begin
                    res_n    = 2'd1;
                    res0     = make_result(KIND_SEGMENT, mid, SEG_BYTES,
                                           {8'h00, frame.data[7:1]}, 1'b0);
                    rcv_next = rcv_reg + 16'(SEG_BYTES);
                    seq_next = seq_reg + 8'd1;
                end
                else
                begin
                    // The end-of-message ack goes first, then the closing segment.
                    res_n     = 2'd2;
                    res0      = make_result(KIND_EOM_ACK, mid, FULL_FRAME,
                                    {group_reg[7:0], group_reg[15:8], group_reg[23:16],
                                     FILL_BYTE, ptotal_reg, total_reg[15:8],
                                     total_reg[7:0], CTRL_EOM_ACK}, 1'b0);
                    res1      = make_result(KIND_SEGMENT, mid, rem[3:0],
                                            {8'h00, frame.data[7:1]}, 1'b1);
                    rcv_next  = rcv_reg + rem;
                    open_next = 1'b0;
                end
            end
        end
        else
        begin
            if (!rule.check || pri == rule.pri)
            begin
                res_n = 2'd1;
                res0  = make_result(KIND_FORWARD, pgn, fwd_count, frame.data, 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            total_reg  <= 16'd0;
            ptotal_reg <= 8'd0;
            rcv_reg    <= 16'd0;
            seq_reg    <= 8'd0;
            group_reg  <= 24'd0;
        end
        else if (fire)
        begin
            open_reg   <= open_next;
            total_reg  <= total_next;
            ptotal_reg <= ptotal_next;
            rcv_reg    <= rcv_next;
            seq_reg    <= seq_next;
            group_reg  <= group_next;
        end
    end

    assign status.session_open = open_reg;

endmodule

### design/ctrp_out_buf.sv
// ----------------------------------------------------------------------------
// ctrp_out_buf
// Two-entry result register for the output stream; push a new pair of results
// only when it will be empty after this cycle. The block does not enforce it.
// ----------------------------------------------------------------------------
module ctrp_out_buf
    import ctrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic [1:0] res_n,
    input  result_t res0,
    input  result_t res1,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t head,
    output logic    room
);

    logic [1:0] cnt_reg,  cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign head      = head_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        priority if (push && res_n != 2'd0)
        begin
            head_next = res0;
            tail_next = res1;
            cnt_next  = res_n;
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

### design/can_tp_rx_reassembler.sv
// ----------------------------------------------------------------------------
// can_tp_rx_reassembler
// Receive side of an RTS/CTS transport protocol over extended CAN frames.
// ----------------------------------------------------------------------------
// One received frame enters per request on the s_axis channel. Each frame
// gives zero, one or two results on m_axis: a CTS frame to send, an
// end-of-message ack to send, a payload segment, or a forwarded frame;
// tuser carries the kind and tlast marks the final payload segment, a CTS
// frame or a forwarded frame.
// A frame is held in an input register and decided as soon as the result
// register has room; its results are registered there and offered on m_axis
// from the result register.
// Frames giving one result can be taken every cycle while m_axis is ready; a
// frame giving two results (ack plus closing segment) fills the two-entry
// result register, and the next frame waits until it drains.
// When m_axis stalls, results stay in the result register and the input
// register fills, after which s_axis_tready falls; nothing is dropped.
// Reset closes any session, clears all session state and sets the maximum
// message length to 1100; cfg_we loads a new limit from cfg_wdata.
// ----------------------------------------------------------------------------
module can_tp_rx_reassembler
    import ctrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_id[28:0], frame_length[32:29], byte0[40:33] .. byte7[96:89], zeros
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // group_code[7:0], count[11:8], out0[19:12] .. out7[75:68], zeros
    output logic [79:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    logic        in_valid_reg;
    frame_t      frame_reg;
    logic [15:0] max_len_reg;
    logic        room;
    logic        fire;
    logic        s_accept;
    logic [1:0]  res_n;
    result_t     res0;
    result_t     res1;
    result_t     head;
    eng_status_t status;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= MAX_LEN_RESET;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            frame_reg.frame_id     <= s_axis_tdata[28:0];
            frame_reg.frame_length <= s_axis_tdata[32:29];
            frame_reg.data         <= s_axis_tdata[96:33];
        end
    end

    ctrp_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .frame   (frame_reg),
        .max_len (max_len_reg),
        .res_n   (res_n),
        .res0    (res0),
        .res1    (res1),
        .status  (status)
    );

    ctrp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res_n     (res_n),
        .res0      (res0),
        .res1      (res1),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .head      (head),
        .room      (room)
    );

    assign m_axis_tdata = {4'h0, head.data, head.count, head.group_code};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // A frame giving two results always closes the session.
    a_two_results_close: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_n == 2'd2 |=> !status.session_open)
        else $error("session still open after the closing data frame");

    // The ack is offered first and is never marked last.
    a_ack_first: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_n == 2'd2 |=> m_axis_tvalid && m_axis_tuser == KIND_EOM_ACK
                                  && !m_axis_tlast)
        else $error("end-of-message ack not at the head of the result register");

    // A held frame is not lost while the result register is full.
    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("pending frame vanished without being decided");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transport-protocol receive reassembler. Frames
// are pushed on s_axis, first a directed set covering the session corner cases
// and the priority filter, then random sessions mixed with stray frames under
// four limit settings and several sender and receiver idling patterns. A
// session tracker predicts every CTS, ack, segment and forwarded frame, and
// each m_axis request is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import ctrp_pkg::*;
;

    localparam int QUIET_LIMIT = 5000;
    localparam logic [15:0] NODE_PAIR = 16'h56F4;

    typedef struct packed {
        logic [7:0][7:0] b;
        logic [3:0]      dlc;
        logic [28:0]     id;
    } rx_frame_t;

    localparam logic [23:0] GOOD_GROUPS [6] = '{24'h000200, 24'h000600, 24'h001100,
                                                24'h001500, 24'h001600, 24'h001700};
    localparam logic [7:0] FILTERED_PGNS [11] = '{8'h27, 8'h10, 8'h1C, 8'h13, 8'h11,
                                                  8'h15, 8'h16, 8'h17, 8'h09, 8'h19,
                                                  8'h1E};
    localparam logic [7:0] PRI_CHOICES [4] = '{8'h08, 8'h10, 8'h18, 8'h1C};

    class tp_rx_tracker;
        typedef struct packed {
            kind_t           kind;
            logic [7:0]      grp;
            logic [3:0]      cnt;
            logic [7:0][7:0] bytes;
            logic            last;
        } due_t;

        due_t        due_results[$];
        int          errors;
        logic [15:0] max_len;
        logic [15:0] msg_len;
        logic [15:0] rx_bytes;
        logic [7:0]  pkt_total;
        logic [7:0]  next_seq;
        logic [23:0] sess_group;
        logic        sess_open;

        function new();
            errors     = 0;
            max_len    = MAX_LEN_RESET;
            msg_len    = '0;
            rx_bytes   = '0;
            pkt_total  = '0;
            next_seq   = '0;
            sess_group = '0;
            sess_open  = 1'b0;
        endfunction

        function void add(kind_t k, logic [7:0] g, logic [3:0] c, logic [7:0][7:0] d,
                          logic l);
            due_t r;
            r.kind = k;
            r.grp  = g;
            r.cnt  = c;
            r.last = l;
            for (int i = 0; i < 8; i++)
            begin
                r.bytes[i] = (i < c) ? d[i] : 8'h00;
            end
            due_results.push_back(r);
        endfunction

        // Priority byte that an ordinary frame must carry, or -1 if unfiltered.
        function int filter_priority(logic [7:0] pgn);
            case (pgn)
                8'h27, 8'h10, 8'h1C, 8'h13: return 'h18;
                8'h11, 8'h15, 8'h16, 8'h17: return 'h1C;
                8'h09, 8'h19:               return 'h10;
                8'h1E:                      return 'h08;
                default:                    return -1;
            endcase
        endfunction

        // Notes one accepted frame and returns how many results it should give.
        function int take_frame(rx_frame_t f);
            logic [7:0]      pri;
            logic [7:0]      pgn;
            logic [7:0]      mid;
            logic [23:0]     grp;
            logic [15:0]     rem;
            logic [7:0][7:0] seg;
            int              need;
            int              prior_size;
            prior_size = due_results.size();
            pri = {3'b000, f.id[28:24]};
            pgn = f.id[23:16];
            seg = {8'h00, f.b[7], f.b[6], f.b[5], f.b[4], f.b[3], f.b[2], f.b[1]};
            if (pgn == PGN_CONN_MGMT)
            begin
                if (pri == PRI_TP && f.b[0] == CTRL_RTS)
                begin
                    grp = {f.b[5], f.b[6], f.b[7]};
                    if (grp inside {24'h000200, 24'h000600, 24'h001100, 24'h001500,
                                    24'h001600, 24'h001700})
                    begin
                        msg_len    = {f.b[2], f.b[1]};
                        pkt_total  = f.b[3];
                        rx_bytes   = '0;
                        next_seq   = 8'd1;
                        sess_group = grp;
                        sess_open  = 1'b0;
                        if (msg_len <= max_len)
                        begin
                            add(KIND_CTS, f.b[6], FULL_FRAME,
                                {f.b[7], f.b[6], f.b[5], FILL_BYTE, FILL_BYTE, 8'd1,
                                 f.b[3], CTRL_CTS}, 1'b1);
                            sess_open = 1'b1;
                        end
                    end
                end
                else if (pri == PRI_TP && f.b[0] == CTRL_ABORT)
                begin
                    sess_open = 1'b0;
                end
            end
            else if (pgn == PGN_DATA && sess_open)
            begin
                rem = msg_len - rx_bytes;
                mid = sess_group[15:8];
                if (pri == PRI_TP && f.b[0] == next_seq && next_seq <= pkt_total)
                begin
                    if (rem > 16'd7)
                    begin
                        add(KIND_SEGMENT, mid, SEG_BYTES, seg, 1'b0);
                        rx_bytes = rx_bytes + 16'd7;
                        next_seq = next_seq + 8'd1;
                    end
                    else
                    begin
                        add(KIND_EOM_ACK, mid, FULL_FRAME,
                            {sess_group[7:0], mid, sess_group[23:16], FILL_BYTE,
                             pkt_total, msg_len[15:8], msg_len[7:0], CTRL_EOM_ACK}, 1'b0);
                        add(KIND_SEGMENT, mid, rem[3:0], seg, 1'b1);
                        rx_bytes  = rx_bytes + rem;
                        sess_open = 1'b0;
                    end
                end
            end
            else
            begin
                need = filter_priority(pgn);
                if (need < 0 || pri == need[7:0])
                begin
                    add(KIND_FORWARD, pgn, (f.dlc > 4'd8) ? 4'd8 : f.dlc, f.b, 1'b1);
                end
            end
            return due_results.size() - prior_size;
        endfunction

        function void check_result(kind_t k, logic [79:0] word, logic l);
            due_t e;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: kind %0d data %h last %b",
                         $time, k, word, l);
                return;
            end
            e = due_results.pop_front();
            if (k !== e.kind)
            begin
                errors++;
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
            end
            if (word[7:0] !== e.grp)
            begin
                errors++;
                $display("%0t: group_code expected %h actual %h", $time, e.grp, word[7:0]);
            end
            if (word[11:8] !== e.cnt)
            begin
                errors++;
                $display("%0t: count expected %0d actual %0d", $time, e.cnt, word[11:8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                if (word[12 + 8 * i +: 8] !== e.bytes[i])
                begin
                    errors++;
                    $display("%0t: out%0d expected %h actual %h", $time, i, e.bytes[i],
                             word[12 + 8 * i +: 8]);
                end
            end
            if (l !== e.last)
            begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, e.last, l);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;

    tp_rx_tracker tracker = new();
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           busy_frames = 0;
    logic [15:0]  cur_limit = MAX_LEN_RESET;

    can_tp_rx_reassembler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Receiver side: check each result request and pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tracker.check_result(kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0][7:0] bytes8(logic [7:0] b0, b1, b2, b3, b4, b5, b6,
                                               b7);
        return {b7, b6, b5, b4, b3, b2, b1, b0};
    endfunction

    function automatic rx_frame_t frame_of(logic [4:0] pri, logic [7:0] pgn,
                                           logic [3:0] dlc, logic [7:0][7:0] b);
        rx_frame_t f;
        f.id  = {pri, pgn, NODE_PAIR};
        f.dlc = dlc;
        f.b   = b;
        return f;
    endfunction

    task automatic push_frame(input rx_frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, f};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (tracker.take_frame(f) > 0)
        begin
            busy_frames++;
        end
    endtask

    task automatic send_rts(input logic [4:0] pri, input logic [15:0] len,
                            input logic [7:0] pkts, input logic [23:0] grp);
        push_frame(frame_of(pri, PGN_CONN_MGMT, 4'd8,
                            bytes8(CTRL_RTS, len[7:0], len[15:8], pkts, FILL_BYTE,
                                   grp[23:16], grp[15:8], grp[7:0])));
    endtask

    task automatic send_ctrl(input logic [4:0] pri, input logic [7:0] ctrl);
        push_frame(frame_of(pri, PGN_CONN_MGMT, 4'd8,
                            {56'({$urandom, $urandom}), ctrl}));
    endtask

    task automatic send_data(input logic [4:0] pri, input logic [7:0] seq,
                             input logic [3:0] dlc);
        push_frame(frame_of(pri, PGN_DATA, dlc, {56'({$urandom, $urandom}), seq}));
    endtask

    task automatic push_noise();
        rx_frame_t f;
        int        pick;
        pick = $urandom_range(9);
        f.id  = 29'($urandom);
        f.dlc = 4'($urandom);
        f.b   = {$urandom, $urandom};
        if (pick < 4)
        begin
            // A frame the priority filter looks at, with a likely priority.
            f.id[23:16] = FILTERED_PGNS[$urandom_range(10)];
            f.id[28:24] = PRI_CHOICES[$urandom_range(3)][4:0];
        end
        else if (pick < 6)
        begin
            f.id[23:16] = PGN_CONN_MGMT;
            if ($urandom_range(1) == 0)
            begin
                f.id[28:24] = PRI_TP[4:0];
            end
        end
        push_frame(f);
    endtask

    // Waits until every predicted result has arrived and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we          <= 1'b0;
        tracker.max_len = v;
        cur_limit       = v;
    endtask

    task automatic random_session();
        int          len;
        int          pkts;
        int          n;
        int          span;
        logic [23:0] grp;
        logic [7:0]  seq;
        logic [4:0]  pri;
        logic [3:0]  dlc;
        span = (cur_limit < 90) ? cur_limit : 90;
        len  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(span);
        pkts = (len + 6) / 7;
        if (pkts == 0 && $urandom_range(3) != 0)
        begin
            pkts = 1;
        end
        if ($urandom_range(9) == 0)
        begin
            pkts = $urandom_range(15);
        end
        grp = ($urandom_range(9) == 0) ? 24'($urandom) : GOOD_GROUPS[$urandom_range(5)];
        pri = ($urandom_range(19) == 0) ? 5'($urandom) : PRI_TP[4:0];
        send_rts(pri, 16'(len), 8'(pkts), grp);
        n = (pkts > 12) ? 12 : ((pkts == 0) ? 1 : pkts);
        for (int i = 1; i <= n; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                push_noise();
            end
            if ($urandom_range(49) == 0)
            begin
                send_ctrl(PRI_TP[4:0], CTRL_ABORT);
            end
            seq = 8'(i);
            if ($urandom_range(19) == 0)
            begin
                seq = seq + 8'($urandom_range(3, 1));
            end
            pri = ($urandom_range(29) == 0) ? 5'($urandom) : PRI_TP[4:0];
            dlc = ($urandom_range(4) == 0) ? 4'($urandom) : 4'd8;
            send_data(pri, seq, dlc);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [15:0] limit, input int goal);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_limit(limit);
        start = busy_frames;
        while (busy_frames - start < goal)
        begin
            if ($urandom_range(3) == 0)
            begin
                push_noise();
            end
            else
            begin
                random_session();
            end
        end
        settle();
    endtask

    task automatic directed_frames();
        // Ordinary frames: extreme fields and the priority filter.
        push_frame(frame_of(5'h00, 8'h00, 4'd0, '0));
        push_frame('{b: '1, dlc: 4'hF, id: 29'h1FFFFFFF});
        push_frame(frame_of(5'h18, 8'h27, 4'd8, {$urandom, $urandom}));
        push_frame(frame_of(5'h1C, 8'h27, 4'd8, {$urandom, $urandom}));
        push_frame(frame_of(5'h08, 8'h1E, 4'd5, {$urandom, $urandom}));
        push_frame(frame_of(5'h10, 8'h09, 4'd3, {$urandom, $urandom}));
        // Connection management that must not open a session.
        send_rts(5'h18, 16'd20, 8'd3, 24'h000200);
        send_ctrl(PRI_TP[4:0], 8'h20);
        send_rts(PRI_TP[4:0], 16'd20, 8'd3, 24'h000300);
        send_rts(PRI_TP[4:0], MAX_LEN_RESET + 16'd1, 8'd158, 24'h001100);
        send_data(PRI_TP[4:0], 8'd1, 4'd8);
        // A three-packet message with a wrong priority and a bad sequence inside.
        send_rts(PRI_TP[4:0], 16'd20, 8'd3, 24'h000200);
        send_data(5'h18, 8'd1, 4'd8);
        send_data(PRI_TP[4:0], 8'd2, 4'd8);
        send_data(PRI_TP[4:0], 8'd1, 4'd8);
        send_data(PRI_TP[4:0], 8'd2, 4'd8);
        send_data(PRI_TP[4:0], 8'd3, 4'd8);
        // Empty message: the ack is followed by a segment of no bytes.
        send_rts(PRI_TP[4:0], 16'd0, 8'd1, 24'h001700);
        send_data(PRI_TP[4:0], 8'd1, 4'd2);
        // Sequence running past the announced packet total, then an abort.
        send_rts(PRI_TP[4:0], 16'd14, 8'd1, 24'h001500);
        send_data(PRI_TP[4:0], 8'd1, 4'd8);
        send_data(PRI_TP[4:0], 8'd2, 4'd8);
        send_ctrl(PRI_TP[4:0], CTRL_ABORT);
        send_data(PRI_TP[4:0], 8'd2, 4'd8);
        // Length exactly at the limit is still accepted.
        send_rts(PRI_TP[4:0], MAX_LEN_RESET, 8'd158, 24'h000600);
        send_ctrl(PRI_TP[4:0], CTRL_ABORT);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_frames();
        settle();
        run_phase(0, 0, 16'hFFFF, 400);
        run_phase(64, 0, 16'h0000, 400);
        run_phase(0, 64, 16'($urandom_range(2000, 30)), 400);
        run_phase(38, 38, MAX_LEN_RESET, 400);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### can_tp_rx_reassembler.f
design/ctrp_pkg.sv
design/ctrp_engine.sv
design/ctrp_out_buf.sv
design/can_tp_rx_reassembler.sv
sim/tb_top.sv
